/* rtl/kgh_pkg.sv */
// Shared types, codes and widths for the karaoke glyph highlighter.
package kgh_pkg;

    // Payload widths
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 16;
    localparam int TIME_W     = 32;
    localparam int PREROLL_W  = 23;
    localparam int COLOR_W    = 24;
    localparam int UNITS_W    = 16;
    localparam int OPA_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Internal arithmetic widths
    localparam int CALC_W     = 50;   // signed times, fallback start may go negative
    localparam int PROD_W     = 48;   // index times per-unit duration
    localparam int LATE_W     = 33;   // time past the end of a word
    localparam int SPAN_W     = 32;   // word duration after the lower clamp
    localparam int DIV_NUM_W  = 42;   // late * 448
    localparam int DIV_DEN_W  = 35;   // span * 5

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREROLL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_DUR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT  = 3'd4;

    // Constants
    localparam logic [COLOR_W-1:0]       COLOR_RESET = 24'hFFDC3C;
    localparam logic [UNITS_W-1:0]       UNITS_RESET = 16'd1;
    localparam logic [OPA_W-1:0]         OPA_FULL    = 9'd256;
    localparam logic signed [CALC_W-1:0] MIN_SPAN_US = CALC_W'(1000);

    typedef struct packed {
        logic [CHAR_W-1:0] first_char;
        logic [CHAR_W-1:0] char_count;
        logic [TIME_W-1:0] begin_us;
        logic [TIME_W-1:0] finish_us;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_MUL,
        ST_OFS,
        ST_END,
        ST_SPAN,
        ST_SCALE,
        ST_OPA_GO,
        ST_OPA_WAIT,
        ST_OUT
    } state_t;

endpackage

/* rtl/kgh_if.sv */
// Channel interfaces: command input, result output and configuration write.
interface kgh_in_if import kgh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [CHAR_W-1:0]   char_index;
    logic [CHAR_W-1:0]   word_index;
    logic [TIME_W-1:0]   time_us;
    logic [CHAR_W-1:0]   entry_char_start;
    logic [CHAR_W-1:0]   entry_char_length;
    logic [TIME_W-1:0]   entry_start_us;
    logic [TIME_W-1:0]   entry_end_us;

    modport source (
        output valid, cmd, char_index, word_index, time_us,
               entry_char_start, entry_char_length, entry_start_us, entry_end_us,
        input  ready
    );
    modport sink (
        input  valid, cmd, char_index, word_index, time_us,
               entry_char_start, entry_char_length, entry_start_us, entry_end_us,
        output ready
    );
endinterface

interface kgh_out_if import kgh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               highlighted;
    logic [COLOR_W-1:0] glyph_color;
    logic [OPA_W-1:0]   glyph_opacity;

    modport source (output valid, highlighted, glyph_color, glyph_opacity, input ready);
    modport sink (input valid, highlighted, glyph_color, glyph_opacity, output ready);
endinterface

interface kgh_cfg_if import kgh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/kgh_div.sv */
// Restoring divider, one quotient bit per cycle.
module kgh_div import kgh_pkg::*; #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 35
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_status_t      status,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W:0]   rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] trial;
    logic             ge;

    // Shift in the next numerator bit, subtract when it fits.
    always_comb
    begin
        rem_sh   = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        trial    = {1'b0, rem_sh} - {2'b00, den_reg};
        ge       = !trial[DEN_W+1];
        rem_next = ge ? trial[DEN_W:0] : rem_sh;
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quo         = quo_reg;

endmodule

/* rtl/karaoke_glyph_highlighter.sv */
// Karaoke glyph highlighter top level: word timing table, sequencer and fade divider.
//
//  Channel   Dir   Handshake      Payload
//  -------   ---   ------------   ---------------------------------------------------
//  in_ch     in    valid/ready    cmd, char/word index, time, entry fields
//  out_ch    out   valid/ready    highlighted, glyph_color, glyph_opacity
//  cfg_ch    in    valid/ready    index (0..4), data (32 bits), always ready
//
//  Clear and append complete when accepted; the block stays ready for the next command.
//  Evaluate steps through each table entry scanned (registered table read, then the
//  span compare), then through the even split when no entry matches (division,
//  multiply, offset), then finds the span, then runs a second division when the glyph
//  is fading, and last loads the result register.
//  The shared restoring divider yields one quotient bit per cycle.
//  Reset empties the table (entry count zero) and restores register defaults; the
//  table storage itself is never cleared. A result waits in the output register while
//  the next transaction is taken; the sequencer holds only if that register is full.
module karaoke_glyph_highlighter import kgh_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    kgh_in_if.sink    in_ch,
    kgh_out_if.source out_ch,
    kgh_cfg_if.sink   cfg_ch
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Sequencer and configuration state
    // ------------------------------------------------------------------
    state_t                 state_reg;
    state_t                 state_next;

    logic                   unit_mode_reg;
    logic [PREROLL_W-1:0]   preroll_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic [TIME_W-1:0]      clip_reg;
    logic [UNITS_W-1:0]     units_reg;

    logic [CNT_W-1:0]       used_reg;
    logic [CNT_W-1:0]       scan_reg;
    logic [CNT_W-1:0]       scan_inc;

    // Word timing table and its registered read port
    entry_t                 table_mem [TABLE_DEPTH];
    entry_t                 rd_data_reg;
    entry_t                 entry_in;

    // Item under evaluation
    logic [CHAR_W-1:0]      ci_reg;
    logic [CHAR_W-1:0]      wi_reg;
    logic [TIME_W-1:0]      now_reg;

    // Timing datapath
    logic [TIME_W-1:0]        per_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [CALC_W-1:0] start_reg;
    logic signed [CALC_W-1:0] end_reg;
    logic signed [CALC_W-1:0] span_reg;
    logic [LATE_W-1:0]        late_reg;
    logic                     hl_reg;
    logic [DIV_NUM_W-1:0]     num_reg;
    logic [DIV_DEN_W-1:0]     den_reg;
    logic [OPA_W-1:0]         opa_reg;

    // Output register
    logic                   out_valid_reg;
    logic                   out_hl_reg;
    logic [COLOR_W-1:0]     out_color_reg;
    logic [OPA_W-1:0]       out_opa_reg;

    // Combinational helpers
    logic                     in_fire;
    logic                     cfg_fire;
    logic                     table_full;
    logic                     mem_we;
    logic                     covers;
    logic [CHAR_W:0]          span_limit;
    logic [CHAR_W-1:0]        idx_c;
    logic [UNITS_W-1:0]       units_eff;
    logic signed [CALC_W-1:0] now_s;
    logic signed [CALC_W-1:0] span_c;
    logic signed [CALC_W-1:0] late_c;
    logic                     hl_c;
    logic                     fade_c;
    logic [SPAN_W-1:0]        span_lo;
    logic [OPA_W-1:0]         opa_div;
    logic                     out_load;

    // Divider hookup
    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic [DIV_NUM_W-1:0]   div_quo;
    div_status_t            div_stat;

    kgh_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_stat),
        .quo    (div_quo)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign in_fire    = in_ch.valid && in_ch.ready;
    assign cfg_fire   = cfg_ch.valid && cfg_ch.ready;
    assign table_full = (used_reg == CNT_W'(TABLE_DEPTH));
    assign scan_inc   = scan_reg + CNT_W'(1);

    assign entry_in.first_char = in_ch.entry_char_start;
    assign entry_in.char_count = in_ch.entry_char_length;
    assign entry_in.begin_us   = in_ch.entry_start_us;
    assign entry_in.finish_us  = in_ch.entry_end_us;

    // An entry covers the glyph when first <= char_index < first + count, no wrap.
    assign span_limit = {1'b0, rd_data_reg.first_char} + {1'b0, rd_data_reg.char_count};
    assign covers     = (ci_reg >= rd_data_reg.first_char) && ({1'b0, ci_reg} < span_limit);

    // Even split: a unit count of zero counts as one.
    assign units_eff = (units_reg == '0) ? UNITS_RESET : units_reg;
    assign idx_c     = unit_mode_reg ? wi_reg : ci_reg;

    assign now_s  = $signed({{(CALC_W - TIME_W){1'b0}}, now_reg});
    assign span_c = end_reg - start_reg;
    assign late_c = now_s - end_reg;
    assign hl_c   = (now_s >= start_reg);
    assign fade_c = (now_s > end_reg);

    // Fade span below 1 ms (or negative) is clamped to 1 ms.
    assign span_lo = (span_reg < MIN_SPAN_US) ? SPAN_W'(MIN_SPAN_US)
                                              : span_reg[SPAN_W-1:0];

    // Opacity drop of 256 or more saturates at fully transparent.
    assign opa_div = (|div_quo[DIV_NUM_W-1:8]) ? '0 : OPA_FULL - OPA_W'(div_quo[7:0]);

    // The divider serves both the per-unit duration and the fade ratio.
    assign div_num = (state_reg == ST_PER_GO) ? DIV_NUM_W'(clip_reg) : num_reg;
    assign div_den = (state_reg == ST_PER_GO) ? DIV_DEN_W'(units_eff) : den_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_ch.cmd == CMD_EVAL))
                begin
                    state_next = (used_reg == '0) ? ST_PER_GO : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (covers)
                begin
                    state_next = ST_SPAN;
                end
                else if (scan_inc == used_reg)
                begin
                    state_next = ST_PER_GO;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_PER_GO:   state_next = ST_PER_WAIT;
            ST_PER_WAIT: state_next = div_stat.done ? ST_MUL : ST_PER_WAIT;
            ST_MUL:      state_next = ST_OFS;
            ST_OFS:      state_next = ST_END;
            ST_END:      state_next = ST_SPAN;
            ST_SPAN:     state_next = (hl_c && fade_c) ? ST_SCALE : ST_OUT;
            ST_SCALE:    state_next = ST_OPA_GO;
            ST_OPA_GO:   state_next = ST_OPA_WAIT;
            ST_OPA_WAIT: state_next = div_stat.done ? ST_OUT : ST_OPA_WAIT;
            ST_OUT:      state_next = out_load ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        div_start   = (state_reg == ST_PER_GO) || (state_reg == ST_OPA_GO);
        out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);
        mem_we      = in_fire && (in_ch.cmd == CMD_APPEND) && !table_full;
    end

    assign cfg_ch.ready = 1'b1;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            unit_mode_reg <= 1'b0;
            preroll_reg   <= '0;
            color_reg     <= COLOR_RESET;
            clip_reg      <= '0;
            units_reg     <= UNITS_RESET;
        end
        else
        begin
            state_reg <= state_next;

            // Table fill count: clear empties, append advances unless full.
            if (in_fire && (in_ch.cmd == CMD_CLEAR))
            begin
                used_reg <= '0;
            end
            else if (mem_we)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end

            // Scan pointer restarts with every transaction.
            if (in_fire)
            begin
                scan_reg <= '0;
            end
            else if ((state_reg == ST_SCAN_CHK) && !covers)
            begin
                scan_reg <= scan_inc;
            end

            // Hold a result until it is taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_fire)
            begin
                unique case (cfg_ch.index)
                    CFG_UNIT_MODE:  unit_mode_reg <= cfg_ch.data[0];
                    CFG_PREROLL:    preroll_reg   <= cfg_ch.data[PREROLL_W-1:0];
                    CFG_COLOR:      color_reg     <= cfg_ch.data[COLOR_W-1:0];
                    CFG_CLIP_DUR:   clip_reg      <= cfg_ch.data[TIME_W-1:0];
                    CFG_UNIT_COUNT: units_reg     <= cfg_ch.data[UNITS_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Table memory: one write port on append, one registered read port for the scan
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[used_reg[IDX_W-1:0]] <= entry_in;
        end
        rd_data_reg <= table_mem[scan_reg[IDX_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Timing datapath, one step per sequencer state
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ci_reg  <= in_ch.char_index;
            wi_reg  <= in_ch.word_index;
            now_reg <= in_ch.time_us;
        end

        // Table hit: take the entry's times as they stand.
        if ((state_reg == ST_SCAN_CHK) && covers)
        begin
            start_reg <= $signed(CALC_W'(rd_data_reg.begin_us));
            end_reg   <= $signed(CALC_W'(rd_data_reg.finish_us));
        end

        if ((state_reg == ST_PER_WAIT) && div_stat.done)
        begin
            per_reg <= div_quo[TIME_W-1:0];
        end

        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(idx_c) * PROD_W'(per_reg);
        end

        if (state_reg == ST_OFS)
        begin
            start_reg <= $signed(CALC_W'(prod_reg) - CALC_W'(preroll_reg));
        end

        if (state_reg == ST_END)
        begin
            end_reg <= start_reg + $signed(CALC_W'(per_reg));
        end

        // Highlight decision; full opacity until the word ends.
        if (state_reg == ST_SPAN)
        begin
            span_reg <= span_c;
            late_reg <= late_c[LATE_W-1:0];
            hl_reg   <= hl_c;
            opa_reg  <= (hl_c && !fade_c) ? OPA_FULL : '0;
        end

        // Fade ratio: (late * 448) / (5 * span), 448/5 being 0.35 in Q1.8.
        if (state_reg == ST_SCALE)
        begin
            num_reg <= DIV_NUM_W'({late_reg, 9'b0}) - DIV_NUM_W'({late_reg, 6'b0});
            den_reg <= DIV_DEN_W'({span_lo, 2'b00}) + DIV_DEN_W'(span_lo);
        end

        if ((state_reg == ST_OPA_WAIT) && div_stat.done)
        begin
            opa_reg <= opa_div;
        end

        if (out_load)
        begin
            out_hl_reg    <= hl_reg;
            out_color_reg <= hl_reg ? color_reg : '0;
            out_opa_reg   <= opa_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.highlighted   = out_hl_reg;
    assign out_ch.glyph_color   = out_color_reg;
    assign out_ch.glyph_opacity = out_opa_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("table fill count beyond depth");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CHK) |-> (scan_reg < used_reg))
        else $error("scan beyond filled entries");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the karaoke glyph highlighter: predictor, stimulus and handshakes.
`timescale 1ns / 1ps

import kgh_pkg::*;

typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_index;
    logic [CHAR_W-1:0] word_index;
    logic [TIME_W-1:0] time_us;
    logic [CHAR_W-1:0] entry_char_start;
    logic [CHAR_W-1:0] entry_char_length;
    logic [TIME_W-1:0] entry_start_us;
    logic [TIME_W-1:0] entry_end_us;
} glyph_cmd_t;

typedef struct {
    logic               highlighted;
    logic [COLOR_W-1:0] glyph_color;
    logic [OPA_W-1:0]   glyph_opacity;
} glyph_res_t;

typedef struct {
    logic                 unit_mode;
    logic [PREROLL_W-1:0] preroll;
    logic [COLOR_W-1:0]   color;
    logic [TIME_W-1:0]    clip;
    logic [UNITS_W-1:0]   units;
} glyph_setup_t;

// Mirror of the word table and registers; predicts the shading of every evaluated glyph.
class glyph_scoreboard #(int DEPTH = 32);
    logic                 per_word;
    logic [PREROLL_W-1:0] preroll;
    logic [COLOR_W-1:0]   color;
    logic [TIME_W-1:0]    clip_len;
    logic [UNITS_W-1:0]   units;
    entry_t               words[DEPTH];
    int                   words_used;
    glyph_res_t           due_glyphs[$];
    int                   mismatches;

    function new();
        per_word   = 1'b0;
        preroll    = '0;
        color      = COLOR_RESET;
        clip_len   = '0;
        units      = UNITS_RESET;
        words_used = 0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_UNIT_MODE:  per_word = data[0];
            CFG_PREROLL:    preroll  = data[PREROLL_W-1:0];
            CFG_COLOR:      color    = data[COLOR_W-1:0];
            CFG_CLIP_DUR:   clip_len = data[TIME_W-1:0];
            CFG_UNIT_COUNT: units    = data[UNITS_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return due_glyphs.size();
    endfunction

    // Timing comes from the first covering word, else from the even split of the clip.
    function glyph_res_t shade_glyph(glyph_cmd_t c);
        longint     now_us, t_begin, t_finish, span, late, fade;
        longint     lo, hi, dur, n_units, per, idx, pre;
        bit         hit;
        glyph_res_t r;
        now_us   = longint'(c.time_us);
        t_begin  = 0;
        t_finish = 0;
        hit      = 1'b0;
        for (int k = 0; k < words_used && !hit; k++) begin
            lo = longint'(words[k].first_char);
            hi = lo + longint'(words[k].char_count);
            if (longint'(c.char_index) >= lo && longint'(c.char_index) < hi) begin
                t_begin  = longint'(words[k].begin_us);
                t_finish = longint'(words[k].finish_us);
                hit      = 1'b1;
            end
        end
        if (!hit) begin
            dur     = longint'(clip_len);
            n_units = longint'(units);
            if (n_units == 0)
                n_units = 1;
            per      = dur / n_units;
            idx      = longint'(per_word ? c.word_index : c.char_index);
            pre      = longint'(preroll);
            t_begin  = idx * per - pre;
            t_finish = t_begin + per;
        end
        if (now_us >= t_begin) begin
            span = t_finish - t_begin;
            if (span < 1000)
                span = 1000;
            if (now_us <= t_finish)
                fade = 256;
            else begin
                late = now_us - t_finish;
                fade = 256 - (late * 448) / (5 * span);
                if (fade < 0)
                    fade = 0;
            end
            r.highlighted   = 1'b1;
            r.glyph_color   = color;
            r.glyph_opacity = fade[OPA_W-1:0];
        end
        else begin
            r.highlighted   = 1'b0;
            r.glyph_color   = '0;
            r.glyph_opacity = '0;
        end
        return r;
    endfunction

    function void note_input(glyph_cmd_t c);
        case (c.cmd)
            CMD_CLEAR:
                words_used = 0;
            CMD_APPEND:
                if (words_used < DEPTH) begin
                    words[words_used].first_char = c.entry_char_start;
                    words[words_used].char_count = c.entry_char_length;
                    words[words_used].begin_us   = c.entry_start_us;
                    words[words_used].finish_us  = c.entry_end_us;
                    words_used++;
                end
            CMD_EVAL:
                due_glyphs = {due_glyphs, shade_glyph(c)};
            default: ;
        endcase
    endfunction

    function void check_result(glyph_res_t got);
        glyph_res_t want;
        if (due_glyphs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("glyph result with none outstanding: hl=%0b color=%06h opacity=%0d",
                         got.highlighted, got.glyph_color, got.glyph_opacity);
            return;
        end
        want = due_glyphs.pop_front();
        if (got.highlighted !== want.highlighted || got.glyph_color !== want.glyph_color
            || got.glyph_opacity !== want.glyph_opacity) begin
            mismatches++;
            if (mismatches <= 10)
                $display("glyph mismatch: expected hl=%0b color=%06h opacity=%0d,",
                         want.highlighted, want.glyph_color, want.glyph_opacity,
                         " got hl=%0b color=%06h opacity=%0d",
                         got.highlighted, got.glyph_color, got.glyph_opacity);
        end
    endfunction
endclass

module tb_top;

    localparam int                 TABLE_DEPTH    = 32;
    localparam logic [CMD_W-1:0]   CMD_UNUSED     = 2'd3;
    localparam int                 SETTLE_CYCLES  = 250;    // outlasts the worst evaluation
    localparam int                 QUIET_LIMIT    = 5000;   // cycles without any transaction
    localparam int                 LONG_HOLD      = 700;
    localparam int                 PHASE_ITEMS    = 55;
    localparam longint             TIME_MAX       = 64'h0000_0000_FFFF_FFFF;

    logic clk;
    logic rst_n;

    kgh_in_if  in_ch();
    kgh_out_if out_ch();
    kgh_cfg_if cfg_ch();

    karaoke_glyph_highlighter #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    glyph_scoreboard #(TABLE_DEPTH) sb;
    glyph_setup_t                   cur_setup;     // what the stimulus aims at
    int                             items_sent;
    int                             tx_burst_left;
    int                             rx_hold_req;   // set by the test sequence, taken by the result sink
    bit                             no_idle;       // both sides run flat out while set
    int                             quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Observe every handshake at the clock edge; values seen here were settled before it.
    // Count cycles without any transaction and give up when the block goes silent.
    always @(posedge clk)
    begin : observe
        glyph_cmd_t taken;
        glyph_res_t shown;
        if (!rst_n)
            quiet = 0;
        else begin
            if (in_ch.valid && in_ch.ready) begin
                taken.cmd               = in_ch.cmd;
                taken.char_index        = in_ch.char_index;
                taken.word_index        = in_ch.word_index;
                taken.time_us           = in_ch.time_us;
                taken.entry_char_start  = in_ch.entry_char_start;
                taken.entry_char_length = in_ch.entry_char_length;
                taken.entry_start_us    = in_ch.entry_start_us;
                taken.entry_end_us      = in_ch.entry_end_us;
                sb.note_input(taken);
            end
            if (out_ch.valid && out_ch.ready) begin
                shown.highlighted   = out_ch.highlighted;
                shown.glyph_color   = out_ch.glyph_color;
                shown.glyph_opacity = out_ch.glyph_opacity;
                sb.check_result(shown);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_reg(cfg_ch.index, cfg_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result sink: alternate random run and stall lengths; a long hold request wins over
    // the pattern so that the block backs up and stalls its input.
    initial
    begin : result_sink
        int hold_left;
        int rx_left;
        bit rx_on;
        hold_left = 0;
        rx_left   = 0;
        rx_on     = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (no_idle)
                out_ch.ready <= 1'b1;
            else begin
                if (rx_left == 0) begin
                    rx_on   = !rx_on;
                    rx_left = rx_on ? $urandom_range(1, 24)
                            : ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                            : $urandom_range(1, 5);
                end
                rx_left--;
                out_ch.ready <= rx_on;
            end
        end
    end

    function automatic longint rand_upto(longint hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return r % (hi + 1);
    endfunction

    // Random content in every field; the caller overwrites the ones that matter.
    function automatic glyph_cmd_t blank_item(logic [CMD_W-1:0] cmd);
        glyph_cmd_t it;
        it.cmd               = cmd;
        it.char_index        = CHAR_W'($urandom);
        it.word_index        = CHAR_W'($urandom);
        it.time_us           = $urandom;
        it.entry_char_start  = CHAR_W'($urandom);
        it.entry_char_length = CHAR_W'($urandom);
        it.entry_start_us    = $urandom;
        it.entry_end_us      = $urandom;
        return it;
    endfunction

    // Pick a time around the glyph's start, inside its span, during the fade or far off.
    function automatic logic [TIME_W-1:0] aim_time(longint s, longint e);
        longint span;
        longint t;
        span = (e - s < 1000) ? 1000 : e - s;
        case ($urandom_range(0, 6))
            0:       t = s + rand_upto(4) - 2;
            1:       t = (e > s) ? s + rand_upto(e - s) : s;
            2:       t = e + rand_upto(3 * span);
            3:       t = e + rand_upto(1);
            4:       t = s - rand_upto(100000);
            5:       t = e + 3 * span + rand_upto(span);
            default: t = rand_upto(TIME_MAX);
        endcase
        if (t < 0)
            t = 0;
        if (t > TIME_MAX)
            t = TIME_MAX;
        return t[TIME_W-1:0];
    endfunction

    // Offer one transaction; insert a random gap between bursts. Return once accepted.
    task automatic send_item(input glyph_cmd_t it);
        if (!no_idle && tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (($urandom_range(0, 5) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4))
                @(posedge clk);
        end
        if (tx_burst_left > 0)
            tx_burst_left--;
        in_ch.valid             <= 1'b1;
        in_ch.cmd               <= it.cmd;
        in_ch.char_index        <= it.char_index;
        in_ch.word_index        <= it.word_index;
        in_ch.time_us           <= it.time_us;
        in_ch.entry_char_start  <= it.entry_char_start;
        in_ch.entry_char_length <= it.entry_char_length;
        in_ch.entry_start_us    <= it.entry_start_us;
        in_ch.entry_end_us      <= it.entry_end_us;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (it.cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_append(input logic [CHAR_W-1:0] first, input logic [CHAR_W-1:0] len,
                               input logic [TIME_W-1:0] b, input logic [TIME_W-1:0] e);
        glyph_cmd_t it;
        it                   = blank_item(CMD_APPEND);
        it.entry_char_start  = first;
        it.entry_char_length = len;
        it.entry_start_us    = b;
        it.entry_end_us      = e;
        send_item(it);
    endtask

    task automatic send_eval(input logic [CHAR_W-1:0] ci, input logic [CHAR_W-1:0] wi,
                             input logic [TIME_W-1:0] t);
        glyph_cmd_t it;
        it            = blank_item(CMD_EVAL);
        it.char_index = ci;
        it.word_index = wi;
        it.time_us    = t;
        send_item(it);
    endtask

    // Drop valid, wait for every outstanding glyph, then let the sequencer go quiet.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Write all five registers; unused upper data bits carry junk.
    task automatic apply_setup(input glyph_setup_t s);
        write_reg(CFG_UNIT_MODE,  {31'($urandom), s.unit_mode});
        write_reg(CFG_PREROLL,    {9'($urandom), s.preroll});
        write_reg(CFG_COLOR,      {8'($urandom), s.color});
        write_reg(CFG_CLIP_DUR,   s.clip);
        write_reg(CFG_UNIT_COUNT, {16'($urandom), s.units});
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        cur_setup = s;
    endtask

    // Phases 1 and 2 hold the register extremes; the rest keep the even split in a range
    // where glyph times land near the clip.
    function automatic glyph_setup_t pick_setup(int phase);
        glyph_setup_t s;
        longint       per;
        longint       n;
        longint       c;
        if (phase == 1)
            s = '{1'b1, 23'd5000000, 24'h000000, 32'hFFFF_FFFF, 16'hFFFF};
        else if (phase == 2)
            s = '{1'b0, 23'h7FFFFF, 24'hFFFFFF, 32'd0, 16'd1};
        else begin
            s.unit_mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       s.preroll = '0;
                1:       s.preroll = 23'h7FFFFF;
                default: s.preroll = PREROLL_W'($urandom_range(0, 5000000));
            endcase
            s.color = COLOR_W'($urandom);
            case ($urandom_range(0, 5))
                0:       s.units = '0;
                1:       s.units = 16'hFFFF;
                default: s.units = UNITS_W'($urandom_range(1, 300));
            endcase
            n   = (s.units == '0) ? 1 : longint'(s.units);
            per = longint'($urandom_range(0, 3000000));
            c   = per * n + rand_upto(n - 1);
            s.clip = (c > TIME_MAX) ? 32'hFFFF_FFFF : c[TIME_W-1:0];
        end
        return s;
    endfunction

    // One lyric line: optionally clear, append a run of words (sometimes enough to overflow
    // the table), then evaluate glyphs aimed at those words or at the even split.
    task automatic run_sequence();
        entry_t            plan[$];
        entry_t            w;
        int                n_words;
        int                roll;
        int                pick;
        logic [CHAR_W-1:0] next_char;
        logic [CHAR_W-1:0] ci;
        logic [CHAR_W-1:0] wi;
        longint            clock_us;
        longint            s;
        longint            e;
        longint            dur;
        longint            n;
        longint            per;
        longint            idx;
        longint            pre;
        roll    = $urandom_range(0, 19);
        n_words = (roll < 3) ? 0 : (roll < 6) ? $urandom_range(28, 36) : $urandom_range(1, 6);
        if ($urandom_range(0, 9) != 0)
            send_item(blank_item(CMD_CLEAR));
        next_char = CHAR_W'($urandom_range(0, 40));
        clock_us  = rand_upto(200000000);
        repeat (n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                w.first_char = CHAR_W'($urandom);
                w.char_count = CHAR_W'($urandom);
                w.begin_us   = $urandom;
                w.finish_us  = $urandom;
            end
            else begin
                w.first_char = next_char;
                w.char_count = ($urandom_range(0, 7) == 0) ? '0
                             : CHAR_W'($urandom_range(1, 6));
                clock_us     = clock_us + rand_upto(400000);
                w.begin_us   = TIME_W'(clock_us);
                // now and then a word that ends before it begins
                if ($urandom_range(0, 7) == 0)
                    w.finish_us = TIME_W'(clock_us - rand_upto(5000) - 1);
                else
                    w.finish_us = TIME_W'(clock_us + rand_upto(900000));
                clock_us = clock_us + rand_upto(900000);
                // mostly advance past the word; otherwise overlap the next one on it
                if ($urandom_range(0, 4) != 0)
                    next_char = next_char + w.char_count;
                next_char = next_char + CHAR_W'($urandom_range(0, 1));
            end
            plan = {plan, w};
            send_append(w.first_char, w.char_count, w.begin_us, w.finish_us);
        end
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 19) == 0)
                send_item(blank_item(CMD_UNUSED));
            wi   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            pick = $urandom_range(0, 9);
            if (plan.size() != 0 && pick < 6) begin
                w  = plan[$urandom_range(0, plan.size() - 1)];
                ci = CHAR_W'(w.first_char + $urandom_range(0, w.char_count + 1) - 1);
                s  = longint'(w.begin_us);
                e  = longint'(w.finish_us);
            end
            else begin
                ci  = (pick < 9) ? 16'($urandom_range(0, 90)) : 16'($urandom);
                dur = longint'(cur_setup.clip);
                n   = (cur_setup.units == '0) ? 1 : longint'(cur_setup.units);
                per = dur / n;
                idx = longint'(cur_setup.unit_mode ? wi : ci);
                pre = longint'(cur_setup.preroll);
                s   = idx * per - pre;
                e   = s + per;
            end
            send_eval(ci, wi, aim_time(s, e));
        end
    endtask

    initial
    begin
        int phase;
        int phase_start;
        sb            = new();
        items_sent    = 0;
        tx_burst_left = 0;
        rx_hold_req   = 0;
        no_idle       = 1'b0;
        rst_n         = 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.cmd               <= CMD_CLEAR;
        in_ch.char_index        <= '0;
        in_ch.word_index        <= '0;
        in_ch.time_us           <= '0;
        in_ch.entry_char_start  <= '0;
        in_ch.entry_char_length <= '0;
        in_ch.entry_start_us    <= '0;
        in_ch.entry_end_us      <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= CFG_UNIT_MODE;
        cfg_ch.data             <= '0;
        cur_setup = '{1'b0, '0, COLOR_RESET, '0, UNITS_RESET};
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: zero clip, so every glyph starts and ends at time zero.
        send_eval(16'd0, 16'd0, 32'd0);
        send_eval(16'd3, 16'd7, 32'd5000);
        drain();

        // Unit count zero acts as one: each character gets the whole second.
        apply_setup('{1'b0, 23'd0, 24'hFFFFFF, 32'd1000000, 16'd0});
        send_eval(16'd0, 16'd0, 32'd0);
        send_eval(16'd1, 16'd0, 32'd999999);
        send_item(blank_item(CMD_UNUSED));
        send_append(16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);     // top of the char range
        send_append(16'd0, 16'd0, 32'd5, 32'd6);                    // zero count covers nothing
        send_append(16'd10, 16'd5, 32'd2000000, 32'd1000000);       // finish before begin
        send_append(16'd0, 16'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_append(16'd20, 16'd1, 32'd0, 32'd1000000);
        send_eval(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_eval(16'd0, 16'd0, 32'd0);
        send_eval(16'd2, 16'd0, 32'hFFFF_FFFF);
        send_eval(16'd12, 16'd0, 32'd1500000);
        send_eval(16'd14, 16'd0, 32'd2000000);
        send_eval(16'd20, 16'd0, 32'd2000000);
        send_eval(16'd5, 16'd0, 32'd6000000);
        send_eval(16'd5, 16'd0, 32'd7000000);
        send_item(blank_item(CMD_CLEAR));
        send_eval(16'hFFFF, 16'd0, 32'hFFFF_FFFF);
        send_eval(16'd4294, 16'd0, 32'hFFFF_FFFF);
        drain();

        // Random lyric lines under a new register setting per phase. Phase 3 backs the
        // block up behind a long receiver hold; phase 4 runs without any idle cycles.
        for (phase = 1; phase <= 8; phase++) begin
            apply_setup(pick_setup(phase));
            no_idle = (phase == 4);
            if (phase == 3)
                rx_hold_req = LONG_HOLD;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                run_sequence();
            drain();
            no_idle = 1'b0;
        end

        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
